// File: rtl/core/lsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the limited second-order setpoint filter.
// No dependencies; imported by every module of the core.
package lsf_pkg;

    // Structure
    localparam int AXES       = 3;
    localparam int NUM_GOALS  = 3;
    localparam int REP_AXES   = (AXES < NUM_GOALS) ? AXES : NUM_GOALS;
    localparam int FRAC_BITS  = 16;
    localparam int DT_BITS    = 16;

    // Field widths
    localparam int POS_W      = 27;
    localparam int VEL_W      = 24;
    localparam int ACC_W      = 24;
    localparam int W_W        = 24;
    localparam int CAP_W      = 23;
    localparam int DT_W       = 16;
    localparam int SQ_W       = 2 * W_W;
    localparam int W2_W       = 32;
    localparam int W2H_W      = W2_W - FRAC_BITS;
    localparam int ERR_W      = POS_W + 1;
    localparam int MA_W       = 26;
    localparam int MB_W       = 28;
    localparam int PROD_W     = 50;
    localparam int SUM_W      = 46;
    localparam int VS_W       = VEL_W + 1;
    localparam int PS_W       = POS_W + 1;

    // Stream and register port widths
    localparam int IN_W       = 104;
    localparam int OUT_W      = 160;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // Limits
    localparam logic signed [POS_W-1:0] POS_LIM   = 27'sd65536000;
    localparam logic [DT_W-1:0]         DT_FLOOR  = 16'd66;
    localparam logic [W_W-1:0]          OMEGA_MIN = 24'd4116;
    localparam logic [W_W-1:0]          OMEGA_MAX = 24'd16711680;
    localparam logic [CAP_W-1:0]        ACC_MIN   = 23'd655;
    localparam logic [CAP_W-1:0]        ACC_MAX   = 23'd6553600;
    localparam logic [CAP_W-1:0]        SPD_MIN   = 23'd3277;
    localparam logic [CAP_W-1:0]        SPD_MAX   = 23'd6553600;

    // Register map (index = paddr[4:2])
    typedef enum logic [2:0] {
        REG_GOAL_X    = 3'd0,
        REG_GOAL_Y    = 3'd1,
        REG_GOAL_Z    = 3'd2,
        REG_OMEGA     = 3'd3,
        REG_ACCEL_CAP = 3'd4,
        REG_SPEED_CAP = 3'd5
    } reg_idx_t;

    // Request kinds carried on s_tuser
    typedef enum logic {
        ACT_INIT = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    // Sequencer steps, shared by the coefficient unit and the lanes
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COEF,
        ST_SQUARE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_DAMP,
        ST_ACC,
        ST_MUL_ADT,
        ST_VEL,
        ST_MUL_VDT,
        ST_POS,
        ST_EMIT
    } seq_state_t;

    // Per-item coefficients broadcast to all lanes
    typedef struct packed {
        logic [FRAC_BITS-1:0] w2_lo;
        logic [W2H_W-1:0]     w2_hi;
        logic [W_W:0]         w_dbl;
        logic [CAP_W-1:0]     acc_cap;
        logic [CAP_W-1:0]     spd_cap;
        logic [DT_W-1:0]      dt;
    } coef_t;

endpackage

// File: rtl/core/lsf_coef.sv
`timescale 1ns / 1ps
// Coefficient unit: clamps bandwidth and limits, floors dt, squares omega.
// Depends on lsf_pkg.
module lsf_coef
    import lsf_pkg::*;
(
    input  logic             clk,
    input  seq_state_t       step,
    input  logic [W_W-1:0]   omega,
    input  logic [CAP_W-1:0] accel_cap,
    input  logic [CAP_W-1:0] speed_cap,
    input  logic [DT_W-1:0]  elapsed,
    output coef_t            coef
);

    logic [W_W-1:0]   w_reg;
    logic [CAP_W-1:0] acc_reg;
    logic [CAP_W-1:0] spd_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [W2_W-1:0]  w2_reg;

    logic [W_W-1:0]   w_clamp;
    logic [CAP_W-1:0] acc_clamp;
    logic [CAP_W-1:0] spd_clamp;
    logic [DT_W-1:0]  dt_floor;
    logic [SQ_W-1:0]  w_sq;

    // range limits on the configured values, dt floor and omega square
    always_comb
    begin
        w_clamp   = (omega < OMEGA_MIN) ? OMEGA_MIN :
                    ((omega > OMEGA_MAX) ? OMEGA_MAX : omega);
        acc_clamp = (accel_cap < ACC_MIN) ? ACC_MIN :
                    ((accel_cap > ACC_MAX) ? ACC_MAX : accel_cap);
        spd_clamp = (speed_cap < SPD_MIN) ? SPD_MIN :
                    ((speed_cap > SPD_MAX) ? SPD_MAX : speed_cap);
        dt_floor  = (elapsed < DT_FLOOR) ? DT_FLOOR : elapsed;
        w_sq      = SQ_W'(w_reg) * SQ_W'(w_reg);
    end

    // latch limits first, square omega on the following step
    always_ff @(posedge clk)
    begin
        case (step)
            ST_COEF:
            begin
                w_reg   <= w_clamp;
                acc_reg <= acc_clamp;
                spd_reg <= spd_clamp;
                dt_reg  <= dt_floor;
            end
            ST_SQUARE:
            begin
                w2_reg <= w_sq[FRAC_BITS +: W2_W];
            end
            default:
            begin
            end
        endcase
    end

    assign coef.w2_lo   = w2_reg[FRAC_BITS-1:0];
    assign coef.w2_hi   = w2_reg[W2_W-1:FRAC_BITS];
    assign coef.w_dbl   = {w_reg, 1'b0};
    assign coef.acc_cap = acc_reg;
    assign coef.spd_cap = spd_reg;
    assign coef.dt      = dt_reg;

endmodule

// File: rtl/core/lsf_lane.sv
`timescale 1ns / 1ps
// One axis lane: holds shaped position and velocity, runs the filter update
// over sequenced steps on one shared multiplier. Depends on lsf_pkg.
module lsf_lane
    import lsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  seq_state_t              step,
    input  coef_t                   coef,
    input  logic signed [POS_W-1:0] goal,
    input  logic signed [POS_W-1:0] meas,
    output logic signed [POS_W-1:0] pos,
    output logic signed [VEL_W-1:0] vel
);

    logic signed [POS_W-1:0]  pos_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [SUM_W-1:0]  t_reg;
    logic signed [SUM_W-1:0]  s_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [POS_W-1:0]  pos_next;
    logic signed [VEL_W-1:0]  vel_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [POS_W-1:0]  meas_sat;

    logic signed [ERR_W-1:0]  err;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_a_x;
    logic signed [PROD_W-1:0] mul_b_x;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] p_shift;
    logic signed [SUM_W-1:0]  acc_raw;
    logic signed [SUM_W-1:0]  acc_hi;
    logic signed [VS_W-1:0]   vel_sum;
    logic signed [VS_W-1:0]   vel_hi;
    logic signed [PS_W-1:0]   pos_sum;

    assign err = ERR_W'(goal) - ERR_W'(pos_reg);

    // multiplier operand select per step
    always_comb
    begin
        case (step)
            ST_MUL_LO:
            begin
                mul_a = MA_W'($signed({1'b0, coef.w2_lo}));
                mul_b = MB_W'(err);
            end
            ST_MUL_HI:
            begin
                mul_a = MA_W'($signed({1'b0, coef.w2_hi}));
                mul_b = MB_W'(err);
            end
            ST_MUL_DAMP:
            begin
                mul_a = MA_W'($signed({1'b0, coef.w_dbl}));
                mul_b = MB_W'(vel_reg);
            end
            ST_MUL_ADT:
            begin
                mul_a = MA_W'(acc_reg);
                mul_b = MB_W'($signed({1'b0, coef.dt}));
            end
            ST_MUL_VDT:
            begin
                mul_a = MA_W'(vel_reg);
                mul_b = MB_W'($signed({1'b0, coef.dt}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_a_x = PROD_W'(mul_a);
        mul_b_x = PROD_W'(mul_b);
        prod    = mul_a_x * mul_b_x;
    end

    // combine and clamp; arithmetic shift gives floor rounding
    always_comb
    begin
        p_shift = p_reg >>> FRAC_BITS;

        acc_raw = s_reg - SUM_W'(p_shift);
        acc_hi  = SUM_W'($signed({1'b0, coef.acc_cap}));
        if (acc_raw > acc_hi)
            acc_next = ACC_W'(acc_hi);
        else if (acc_raw < -acc_hi)
            acc_next = ACC_W'(-acc_hi);
        else
            acc_next = ACC_W'(acc_raw);

        vel_sum = VS_W'(vel_reg) + VS_W'(p_reg >>> DT_BITS);
        vel_hi  = VS_W'($signed({1'b0, coef.spd_cap}));
        if (vel_sum > vel_hi)
            vel_next = VEL_W'(vel_hi);
        else if (vel_sum < -vel_hi)
            vel_next = VEL_W'(-vel_hi);
        else
            vel_next = VEL_W'(vel_sum);

        pos_sum = PS_W'(pos_reg) + PS_W'(p_reg >>> DT_BITS);
        if (pos_sum > PS_W'(POS_LIM))
            pos_next = POS_LIM;
        else if (pos_sum < -PS_W'(POS_LIM))
            pos_next = -POS_LIM;
        else
            pos_next = POS_W'(pos_sum);

        if (meas > POS_LIM)
            meas_sat = POS_LIM;
        else if (meas < -POS_LIM)
            meas_sat = -POS_LIM;
        else
            meas_sat = meas;
    end

    // working registers of the update
    always_ff @(posedge clk)
    begin
        case (step)
            ST_MUL_LO, ST_MUL_ADT, ST_MUL_VDT:
            begin
                p_reg <= prod;
            end
            ST_MUL_HI:
            begin
                p_reg <= prod;
                t_reg <= SUM_W'(p_shift);
            end
            ST_MUL_DAMP:
            begin
                p_reg <= prod;
                s_reg <= SUM_W'(p_reg) + t_reg;
            end
            ST_ACC:
            begin
                acc_reg <= acc_next;
            end
            default:
            begin
            end
        endcase
    end

    // axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else
        begin
            case (step)
                ST_LOAD:
                begin
                    pos_reg <= meas_sat;
                    vel_reg <= '0;
                end
                ST_VEL:
                begin
                    vel_reg <= vel_next;
                end
                ST_POS:
                begin
                    pos_reg <= pos_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pos = pos_reg;
    assign vel = vel_reg;

endmodule

// File: rtl/core/lsf_merge.sv
`timescale 1ns / 1ps
// Merge stage: packs the lane results into one request and holds it in the
// output register until taken. Depends on lsf_pkg.
module lsf_merge
    import lsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [POS_W-1:0] pos [AXES],
    input  logic signed [VEL_W-1:0] vel [AXES],
    output logic                    can_load,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata
);

    logic             valid_reg;
    logic             valid_next;
    logic [OUT_W-1:0] data_reg;
    logic [OUT_W-1:0] pack;

    // positions first, then velocities; missing axes read as zero
    always_comb
    begin
        pack = '0;
        for (int k = 0; k < REP_AXES; k++)
        begin
            pack[k*POS_W +: POS_W]                   = pos[k];
            pack[NUM_GOALS*POS_W + k*VEL_W +: VEL_W] = vel[k];
        end
    end

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= pack;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: rtl/core/limited_second_order_setpoint_filter_core.sv
`timescale 1ns / 1ps
// Top level of the three-axis limited second-order setpoint filter.
// Depends on lsf_pkg, lsf_coef, lsf_lane and lsf_merge.
//
//  Channel   Direction  Width  Contents
//  s_*       in         104    tdata: elapsed, meas_x, meas_y, meas_z; tuser: action
//  m_*       out        160    tdata: shaped_x..z, rate_x..z
//  APB       in/out     32     goal_x, goal_y, goal_z, omega, accel_cap, speed_cap
//
// A step request passes the coefficient and omega square steps and the five
// dependent multiplies each lane runs on its single multiplier before the next
// acceptance; an init request only loads and emits. The lanes run in parallel.
// Reset loads the register defaults and zero pose and velocity on every axis.
// A result stalled at the output holds the sequencer in its emit step; one
// finished result waits in the output register while the next request works.
module limited_second_order_setpoint_filter_core
    import lsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // elapsed[15:0], meas_x, meas_y, meas_z, zero pad
    input  logic [0:0]        s_tuser,  // action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,  // shaped_x, shaped_y, shaped_z, rate_x..z, pad
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic signed [POS_W-1:0] goal_reg [NUM_GOALS];
    logic [W_W-1:0]          omega_reg;
    logic [CAP_W-1:0]        acc_cap_reg;
    logic [CAP_W-1:0]        spd_cap_reg;

    logic [DT_W-1:0]         elapsed_reg;
    logic signed [POS_W-1:0] meas_reg [NUM_GOALS];

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic                    accept;
    logic                    emit;
    logic                    can_load;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    coef_t                   coef;

    logic signed [POS_W-1:0] lane_goal [AXES];
    logic signed [POS_W-1:0] lane_meas [AXES];
    logic signed [POS_W-1:0] lane_pos  [AXES];
    logic signed [VEL_W-1:0] lane_vel  [AXES];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg[0] <= '0;
            goal_reg[1] <= '0;
            goal_reg[2] <= 27'sd131072;
            omega_reg   <= 24'd144135;
            acc_cap_reg <= 23'd22938;
            spd_cap_reg <= 23'd16384;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GOAL_X:    goal_reg[0] <= $signed(pwdata[POS_W-1:0]);
                REG_GOAL_Y:    goal_reg[1] <= $signed(pwdata[POS_W-1:0]);
                REG_GOAL_Z:    goal_reg[2] <= $signed(pwdata[POS_W-1:0]);
                REG_OMEGA:     omega_reg   <= pwdata[W_W-1:0];
                REG_ACCEL_CAP: acc_cap_reg <= pwdata[CAP_W-1:0];
                REG_SPEED_CAP: spd_cap_reg <= pwdata[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GOAL_X:    prdata = DATA_W'(unsigned'(goal_reg[0]));
            REG_GOAL_Y:    prdata = DATA_W'(unsigned'(goal_reg[1]));
            REG_GOAL_Z:    prdata = DATA_W'(unsigned'(goal_reg[2]));
            REG_OMEGA:     prdata = DATA_W'(omega_reg);
            REG_ACCEL_CAP: prdata = DATA_W'(acc_cap_reg);
            REG_SPEED_CAP: prdata = DATA_W'(spd_cap_reg);
            default:       prdata = '0;
        endcase
    end

    // input capture
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg <= s_tdata[DT_W-1:0];
            for (int k = 0; k < NUM_GOALS; k++)
                meas_reg[k] <= $signed(s_tdata[DT_W + k*POS_W +: POS_W]);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = (action_t'(s_tuser[0]) == ACT_STEP) ? ST_COEF : ST_LOAD;
            end
            ST_LOAD:     state_next = ST_EMIT;
            ST_COEF:     state_next = ST_SQUARE;
            ST_SQUARE:   state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_DAMP;
            ST_MUL_DAMP: state_next = ST_ACC;
            ST_ACC:      state_next = ST_MUL_ADT;
            ST_MUL_ADT:  state_next = ST_VEL;
            ST_VEL:      state_next = ST_MUL_VDT;
            ST_MUL_VDT:  state_next = ST_POS;
            ST_POS:      state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    lsf_coef u_coef (
        .clk       (clk),
        .step      (state_reg),
        .omega     (omega_reg),
        .accel_cap (acc_cap_reg),
        .speed_cap (spd_cap_reg),
        .elapsed   (elapsed_reg),
        .coef      (coef)
    );

    // one lane per axis; axes past the third see zero goal and measurement
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        if (a < NUM_GOALS)
        begin : g_src
            assign lane_goal[a] = goal_reg[a];
            assign lane_meas[a] = meas_reg[a];
        end
        else
        begin : g_zero
            assign lane_goal[a] = '0;
            assign lane_meas[a] = '0;
        end

        lsf_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (state_reg),
            .coef  (coef),
            .goal  (lane_goal[a]),
            .meas  (lane_meas[a]),
            .pos   (lane_pos[a]),
            .vel   (lane_vel[a])
        );
    end

    lsf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit),
        .pos      (lane_pos),
        .vel      (lane_vel),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/lsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the setpoint filter core, bound to the top level.
// Depends on lsf_pkg and limited_second_order_setpoint_filter_core.
module lsf_checker
    import lsf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // an accepted request keeps the core busy in the cycle after acceptance
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("core ready right after accepting a request");

    // stalled result holds
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
    ) else $error("stalled result changed or dropped");

    // shaped positions stay saturated
    a_pos_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ($signed(m_tdata[26:0])  <= 27'sd65536000) &&
            ($signed(m_tdata[26:0])  >= -27'sd65536000) &&
            ($signed(m_tdata[53:27]) <= 27'sd65536000) &&
            ($signed(m_tdata[53:27]) >= -27'sd65536000) &&
            ($signed(m_tdata[80:54]) <= 27'sd65536000) &&
            ($signed(m_tdata[80:54]) >= -27'sd65536000)
    ) else $error("shaped position outside saturation range");

    // velocities never exceed the largest speed limit
    a_rate_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ($signed(m_tdata[104:81])  <= 24'sd6553600) &&
            ($signed(m_tdata[104:81])  >= -24'sd6553600) &&
            ($signed(m_tdata[128:105]) <= 24'sd6553600) &&
            ($signed(m_tdata[128:105]) >= -24'sd6553600) &&
            ($signed(m_tdata[152:129]) <= 24'sd6553600) &&
            ($signed(m_tdata[152:129]) >= -24'sd6553600)
    ) else $error("shaped velocity outside speed limit range");

endmodule

bind limited_second_order_setpoint_filter_core lsf_checker u_lsf_checker (.*);
